>>> src/srer_pkg.sv
// ----------------------------------------------------------------------------
// srer_pkg
// shared types and constants of the shift-reduce expression recognizer
// ----------------------------------------------------------------------------
package srer_pkg;

  // stack capacity and derived widths
  localparam int STACK_DEPTH = 64;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int MEM_WORDS   = 2 ** ADDR_W;

  // grammar symbol codes held on the stack
  typedef enum logic [2:0] {
    SYM_INERT = 3'd0,
    SYM_ID    = 3'd1,
    SYM_E     = 3'd2,
    SYM_PLUS  = 3'd3,
    SYM_STAR  = 3'd4,
    SYM_OPEN  = 3'd5,
    SYM_CLOSE = 3'd6
  } sym_e;

  // back-end sequencer states
  typedef enum logic [1:0] {
    ST_FETCH,
    ST_REDUCE,
    ST_FILL1,
    ST_FILL2
  } state_e;

  // classified word handed from front to back
  typedef struct packed {
    sym_e code;
    logic last;
  } item_t;

  // one result word
  typedef struct packed {
    logic       overflow;
    logic       accepted;
    logic       done_res;
    logic [1:0] reductions;
    logic [6:0] depth;
  } result_t;

endpackage

>>> src/srer_front.sv
// ----------------------------------------------------------------------------
// srer_front
// input classifier and two-entry queue toward the stack engine
// ----------------------------------------------------------------------------
module srer_front import srer_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_symbol_i,
  input  logic       in_last_i,
  output logic       q_valid_o,
  input  logic       q_ready_i,
  output item_t      q_item_o
);

  function automatic sym_e classify(input logic [7:0] ch);
    sym_e code;
    code = SYM_INERT;
    if ((ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A)) begin
      code = SYM_ID;
    end else begin
      case (ch)
        8'h2B:   code = SYM_PLUS;
        8'h2A:   code = SYM_STAR;
        8'h28:   code = SYM_OPEN;
        8'h29:   code = SYM_CLOSE;
        default: code = SYM_INERT;
      endcase
    end
    return code;
  endfunction

  item_t      slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign in_ready_o = (count_q != 2'd2);
  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = slot_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({push, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= '{code: classify(in_symbol_i), last: in_last_i};
    end
  end

endmodule

>>> src/srer_back.sv
// ----------------------------------------------------------------------------
// srer_back
// stack engine: shift, greedy reduction on a cached top window, verdict
// ----------------------------------------------------------------------------
module srer_back import srer_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_valid_i,
  output logic    q_ready_o,
  input  item_t   q_item_i,
  output logic    res_valid_o,
  input  logic    res_ready_i,
  output result_t res_o
);

  state_e               state_q, state_d;
  logic [DEPTH_W-1:0]   depth_q, depth_d;
  logic                 ovf_q, ovf_d;
  logic [1:0]           cnt_q, cnt_d;
  logic                 last_q, last_d;
  sym_e                 t0_q, t1_q, t2_q, t0_d, t1_d, t2_d;

  // stack below the top three entries
  logic [2:0]           mem_q [MEM_WORDS];
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr, rd_addr;
  logic [2:0]           rd_data_q;

  logic full, red3, red1;
  logic [1:0] cnt_inc;

  assign full    = (depth_q == DEPTH_W'(STACK_DEPTH));
  assign red3    = (depth_q >= DEPTH_W'(3)) &&
                   ((t2_q == SYM_E && t0_q == SYM_E &&
                     (t1_q == SYM_PLUS || t1_q == SYM_STAR)) ||
                    (t2_q == SYM_OPEN && t1_q == SYM_E && t0_q == SYM_CLOSE));
  assign red1    = (depth_q != '0) && (t0_q == SYM_ID);
  assign cnt_inc = (cnt_q == 2'd3) ? cnt_q : cnt_q + 2'd1;

  always_comb begin
    state_d     = state_q;
    depth_d     = depth_q;
    ovf_d       = ovf_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    t0_d        = t0_q;
    t1_d        = t1_q;
    t2_d        = t2_q;
    wr_en       = 1'b0;
    wr_addr     = ADDR_W'(depth_q - DEPTH_W'(3));
    rd_addr     = ADDR_W'(depth_q - DEPTH_W'(4));
    q_ready_o   = 1'b0;
    res_valid_o = 1'b0;

    res_o.depth      = 7'(depth_q);
    res_o.reductions = cnt_q;
    res_o.done_res   = last_q;
    res_o.accepted   = last_q && !ovf_q && (depth_q == DEPTH_W'(1)) && (t0_q == SYM_E);
    res_o.overflow   = ovf_q;

    unique case (state_q)
      ST_FETCH: begin
        q_ready_o = 1'b1;
        if (q_valid_i) begin
          cnt_d   = 2'd0;
          last_d  = q_item_i.last;
          state_d = ST_REDUCE;
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            // spill the deepest cached entry
            wr_en   = (depth_q >= DEPTH_W'(3));
            t2_d    = t1_q;
            t1_d    = t0_q;
            t0_d    = q_item_i.code;
            depth_d = depth_q + DEPTH_W'(1);
          end
        end
      end
      ST_REDUCE: begin
        if (red3) begin
          // fold three into one E, refill the window from memory
          t0_d    = SYM_E;
          depth_d = depth_q - DEPTH_W'(2);
          cnt_d   = cnt_inc;
          state_d = ST_FILL1;
        end else if (red1) begin
          t0_d  = SYM_E;
          cnt_d = cnt_inc;
        end else begin
          res_valid_o = 1'b1;
          if (res_ready_i) begin
            state_d = ST_FETCH;
            if (last_q) begin
              depth_d = '0;
              ovf_d   = 1'b0;
            end
          end
        end
      end
      ST_FILL1: begin
        t1_d    = sym_e'(rd_data_q);
        rd_addr = ADDR_W'(depth_q - DEPTH_W'(3));
        state_d = ST_FILL2;
      end
      ST_FILL2: begin
        t2_d    = sym_e'(rd_data_q);
        state_d = ST_REDUCE;
      end
      default: state_d = ST_FETCH;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FETCH;
      depth_q <= '0;
      ovf_q   <= 1'b0;
      cnt_q   <= 2'd0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      depth_q <= depth_d;
      ovf_q   <= ovf_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t0_q <= t0_d;
    t1_q <= t1_d;
    t2_q <= t2_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= t2_q;
    rd_data_q <= mem_q[rd_addr];
  end

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FETCH && q_valid_i && !full)
      |=> depth_q == DEPTH_W'($past(depth_q) + DEPTH_W'(1)))
    else $error("shift did not grow the stack");

  a_full_sets_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FETCH && q_valid_i && full) |=> ovf_q)
    else $error("shift on full stack did not flag overflow");

  a_fold_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REDUCE && red3)
      |=> (depth_q == DEPTH_W'($past(depth_q) - DEPTH_W'(2)) && state_q == ST_FILL1))
    else $error("three-symbol fold lost track of depth");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_ready_i && last_q) |=> (depth_q == '0 && !ovf_q))
    else $error("stack not cleared after last word");

endmodule

>>> src/shift_reduce_expression_recognizer.sv
// ----------------------------------------------------------------------------
// shift_reduce_expression_recognizer
// streaming recognizer for E -> E+E | E*E | (E) | id, one character per word
// ----------------------------------------------------------------------------
// Each input word carries one character; letters shift as id, + * ( ) as
// themselves, anything else as an inert symbol that blocks reduction. After
// every shift the stack top is reduced greedily and one result word comes
// out with the depth, the reduction count (saturating at 3), the sticky
// overflow flag and, on the word marked tlast, the accept verdict, after
// which the stack clears. In the stack engine every word passes through the
// fetch state and then the reduce state; an id reduction stays in the reduce
// state, while a three-symbol fold goes through the fill states FILL1 and
// FILL2 before reducing again. Folds take this longer path because the
// top-of-stack window is refilled through the stack memory's single
// registered read port. A two-entry queue in front and an output register
// behind let either side stall on its own.
module shift_reduce_expression_recognizer import srer_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
  input  logic        s_axis_tlast,   // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [6:0] depth, [8:7] reductions,
                                      // [9] accepted, [10] overflow, rest zero
  output logic        m_axis_tlast    // done_res
);

  // front to back queue
  logic    q_valid, q_ready;
  item_t   q_item;

  // back to output register
  logic    res_valid, res_ready;
  result_t res;

  // output register
  logic    out_valid_q;
  result_t out_q;

  srer_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_symbol_i (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .q_valid_o   (q_valid),
    .q_ready_i   (q_ready),
    .q_item_o    (q_item)
  );

  srer_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_item_i    (q_item),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // slot frees when empty or being drained this cycle
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_q.done_res;
  assign m_axis_tdata  = {5'd0, out_q.overflow, out_q.accepted, out_q.reductions,
                          out_q.depth};

endmodule
